### src/qpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_pkg
// Types, character constants and helpers shared by the quoted-printable
// encoder modules.
// ----------------------------------------------------------------------------
package qpe_pkg;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_EQ    = 8'h3D;

   localparam logic [7:0] LINE_LIMIT_RESET = 8'd75;

   // register indexes (byte address / 4)
   localparam logic REG_LINE_LIMIT = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } qpe_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
   } qpe_rsp_type;

   // one classified input byte, as queued between front and back
   typedef struct packed {
      logic       brk;       // soft break "=\r\n" goes first
      logic       esc;       // '=' plus two hex digits
      logic       crlf;      // bare LF, sent as CR LF
      logic [7:0] data_byte;
   } qpe_tok_type;

   function automatic logic is_special(input logic [7:0] b);
      logic hit;
      case (b)
         8'h3F, 8'h3D, 8'h21, 8'h22, 8'h23, 8'h24, 8'h40, 8'h5B,
         8'h5C, 8'h5D, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] c;
      if (v > 4'd9) begin
         c = 8'h37 + {4'b0, v};   // 'A' - 10
      end else begin
         c = 8'h30 + {4'b0, v};
      end
      return c;
   endfunction

endpackage

### src/qpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_front
// Takes input bytes, decides escape, line-feed expansion and soft breaks,
// and keeps the line length and previous-CR state.
// ----------------------------------------------------------------------------
module qpe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           line_limit,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qpe_pkg::qpe_req_type req_data,
   output logic                 tok_push,
   output qpe_pkg::qpe_tok_type tok_data,
   input  logic                 tok_full
);
   import qpe_pkg::*;

   logic [7:0] line_len_ff, line_len_in;
   logic       prev_cr_ff, prev_cr_in;

   logic       is_lf, is_cr, esc, brk;
   logic [1:0] width;
   logic [8:0] sum, nsum;
   logic [7:0] base;

   assign req_ready = !tok_full;
   assign tok_push  = req_valid && !tok_full;

   always_comb begin
      is_lf = (req_data.data_byte == CH_LF);
      is_cr = (req_data.data_byte == CH_CR);
      esc   = !is_lf && !is_cr &&
              (req_data.data_byte[7] || is_special(req_data.data_byte) ||
               (req_data.is_final && (req_data.data_byte == CH_SPACE ||
                                      req_data.data_byte == CH_TAB)));
      width = esc ? 2'd3 : 2'd1;
      sum   = {1'b0, line_len_ff} + {7'b0, width};
      brk   = !is_lf && !is_cr && (line_len_ff != 8'd0) && (sum > {1'b0, line_limit});
      base  = brk ? 8'd0 : line_len_ff;
      nsum  = {1'b0, base} + {7'b0, width};

      tok_data.brk       = brk;
      tok_data.esc       = esc;
      tok_data.crlf      = is_lf && !prev_cr_ff;
      tok_data.data_byte = req_data.data_byte;

      if (req_data.is_final || is_lf) begin
         line_len_in = 8'd0;
      end else if (is_cr) begin
         line_len_in = line_len_ff;
      end else begin
         line_len_in = nsum[8] ? 8'hFF : nsum[7:0];
      end
      prev_cr_in = is_cr && !req_data.is_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= 8'd0;
         prev_cr_ff  <= 1'b0;
      end else if (tok_push) begin
         line_len_ff <= line_len_in;
         prev_cr_ff  <= prev_cr_in;
      end
   end

endmodule

### src/qpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_queue
// Small first-in first-out queue of classified tokens between front and back.
// ----------------------------------------------------------------------------
module qpe_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qpe_pkg::qpe_tok_type push_data,
   output logic                 full,
   input  logic                 pop,
   output qpe_pkg::qpe_tok_type head_data,
   output logic                 head_valid
);
   import qpe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   qpe_tok_type         mem [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count above depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");

endmodule

### src/qpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_back
// Walks one token into its output characters, one per cycle into an output
// register while rsp_ready does not stall it.
// ----------------------------------------------------------------------------
module qpe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  qpe_pkg::qpe_tok_type tok_data,
   output logic                 tok_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qpe_pkg::qpe_rsp_type rsp_data
);
   import qpe_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   qpe_rsp_type rsp_data_ff, rsp_data_in;

   logic [2:0]  brk_len, body_len, total, bidx;
   logic        last, load;
   logic [7:0]  ch;

   always_comb begin
      brk_len  = tok_data.brk ? 3'd3 : 3'd0;
      body_len = tok_data.esc ? 3'd3 : (tok_data.crlf ? 3'd2 : 3'd1);
      total    = brk_len + body_len;
      last     = (step_ff == total - 3'd1);
      bidx     = step_ff - brk_len;

      if (tok_data.brk && step_ff < 3'd3) begin
         case (step_ff[1:0])
            2'd0:    ch = CH_EQ;
            2'd1:    ch = CH_CR;
            default: ch = CH_LF;
         endcase
      end else if (tok_data.esc) begin
         case (bidx[1:0])
            2'd0:    ch = CH_EQ;
            2'd1:    ch = hex_digit(tok_data.data_byte[7:4]);
            default: ch = hex_digit(tok_data.data_byte[3:0]);
         endcase
      end else if (tok_data.crlf) begin
         ch = (bidx[1:0] == 2'd0) ? CH_CR : CH_LF;
      end else begin
         ch = tok_data.data_byte;
      end

      load         = tok_valid && (!rsp_valid_ff || rsp_ready);
      tok_pop      = load && last;
      step_in      = load ? (last ? 3'd0 : step_ff + 3'd1) : step_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = load ? '{out_char: ch, run_end: last} : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < 3'd6) else $error("token step out of range");
   a_step_restart: assert property (@(posedge clock) disable iff (reset)
      tok_pop |=> step_ff == 3'd0) else $error("step not cleared after token");
   a_pop_marks_end: assert property (@(posedge clock) disable iff (reset)
      tok_pop |=> rsp_valid && rsp_data.run_end)
      else $error("token retired without run end");

endmodule

### src/quoted_printable_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_encoder_unit
// Byte-serial quoted-printable encoder with a programmable soft line limit.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Transfer carries
//  req_     in   req_valid/req_ready  one message byte plus last-byte flag
//  rsp_     out  rsp_valid/rsp_ready  one encoded character plus run end
//  csr_     in   APB psel/penable     line_limit at byte address 0
//
//  Each input byte produces 1 to 6 characters (1 plain, 2 for CR LF, 3
//  escaped, plus 3 for a soft break); the back end sends one character per
//  cycle while rsp_ready does not stall it.
//  The front accepts a byte per cycle while the token queue has room, so
//  input transfers keep flowing while a result waits on rsp_ready.
//  Reset is synchronous and clears line state, the queue and output valid;
//  line_limit returns to 75.
// ----------------------------------------------------------------------------
module quoted_printable_encoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qpe_pkg::qpe_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qpe_pkg::qpe_rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import qpe_pkg::*;

   // configuration register
   logic [7:0]  line_limit_ff, line_limit_in;
   logic        csr_wr;

   // front to queue, queue to back
   logic        tok_push, tok_full, tok_pop, tok_valid;
   qpe_tok_type tok_in, tok_head;

   assign csr_pready = 1'b1;
   // word index is paddr[2]; only index zero holds a register
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_LINE_LIMIT);
   assign line_limit_in = csr_wr ? csr_pwdata[7:0] : line_limit_ff;
   assign csr_prdata = (csr_paddr[2] == REG_LINE_LIMIT) ? {24'b0, line_limit_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LINE_LIMIT_RESET;
      end else begin
         line_limit_ff <= line_limit_in;
      end
   end

   // classify bytes and track line state
   qpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .line_limit (line_limit_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .tok_push   (tok_push),
      .tok_data   (tok_in),
      .tok_full   (tok_full)
   );

   // decouples classification from character output
   qpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (tok_push),
      .push_data  (tok_in),
      .full       (tok_full),
      .pop        (tok_pop),
      .head_data  (tok_head),
      .head_valid (tok_valid)
   );

   // expand tokens into characters
   qpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok_data  (tok_head),
      .tok_pop   (tok_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quoted_printable_encoder_unit. Message bytes are
// pushed through the req_ channel in random bursts while rsp_ is stalled on
// its own pattern. A cycle-free predictor tracks line length and CR history,
// builds the encoded characters for every byte, and a monitor compares each
// rsp_ transfer against the oldest one. line_limit is rewritten between
// phases over the APB port.
// ----------------------------------------------------------------------------
module testbench;
   import qpe_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer at all
   localparam int DRAIN_CYCLES = 16;     // settle time once nothing is owed
   localparam int PHASE_ITEMS  = 14;

   localparam logic [2:0] LIMIT_ADDR = {REG_LINE_LIMIT, 2'b00};

   // the sixteen bytes that always get escaped; backtick given as hex
   localparam logic [127:0] QP_SPECIALS = {"?=!\"#$@[\\]^", 8'h60, "{|}~"};
   localparam logic [127:0] HEX_CHARS   = "0123456789ABCDEF";

   // ---------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   qpe_req_type req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   qpe_rsp_type rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   quoted_printable_encoder_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Encoder shadow state and the characters still owed by the DUT
   // ---------------------------------------------------------------------
   logic [7:0]  line_len     = '0;
   logic        after_cr     = 1'b0;
   logic [7:0]  limit_shadow = LINE_LIMIT_RESET;
   qpe_rsp_type expected_chars [$];

   int errors        = 0;
   int bytes_sent    = 0;
   int messages_sent = 0;
   int chars_checked = 0;
   int soft_breaks   = 0;
   int limits_used   = 1;     // the reset value counts as one setting
   int burst_left    = 0;
   int quiet_cycles  = 0;

   function automatic bit is_qp_special(input logic [7:0] b);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (QP_SPECIALS[i*8 +: 8] == b) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return HEX_CHARS[(15 - nib) * 8 +: 8];
   endfunction

   // Encode one byte against the shadow state and queue the characters it
   // must produce; run_end marks the last one.
   function automatic void predict_encoding(input qpe_req_type item);
      logic [7:0]  chars [6];
      int          n;
      int          width;
      int          sum;
      bit          esc;
      logic [7:0]  b;
      qpe_rsp_type entry;
      n = 0;
      b = item.data_byte;
      if (b == CH_LF) begin
         // bare LF grows a CR; LF right after CR goes alone
         if (!after_cr) begin
            chars[n] = CH_CR;
            n++;
         end
         chars[n] = CH_LF;
         n++;
         line_len = '0;
      end else if (b == CH_CR) begin
         // no break check and no length, so CR LF never splits
         chars[n] = CH_CR;
         n++;
      end else begin
         esc = b[7] || is_qp_special(b) ||
               (item.is_final && (b == CH_SPACE || b == CH_TAB));
         width = esc ? 3 : 1;
         if (line_len != 0 && int'(line_len) + width > int'(limit_shadow)) begin
            chars[0] = CH_EQ;
            chars[1] = CH_CR;
            chars[2] = CH_LF;
            n = 3;
            line_len = '0;
            soft_breaks++;
         end
         if (esc) begin
            chars[n]     = CH_EQ;
            chars[n + 1] = hex_char(b[7:4]);
            chars[n + 2] = hex_char(b[3:0]);
            n += 3;
         end else begin
            chars[n] = b;
            n++;
         end
         sum = int'(line_len) + width;
         line_len = (sum > 255) ? 8'd255 : 8'(sum);
      end
      after_cr = (b == CH_CR);
      if (item.is_final) begin
         // next message starts clean
         line_len = '0;
         after_cr = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         entry.out_char = chars[i];
         entry.run_end  = (i == n - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gap after each burst. Valid
   // stays high across a burst; it only drops at a burst end or a drain.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input bit last);
      qpe_req_type item;
      item.data_byte = value;
      item.is_final  = last;
      if (burst_left == 0) begin
         // now and then a long run with no gaps at all
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      // prediction is made at drive time; the item cannot be dropped
      predict_encoding(item);
      req_data <= item;
      if (!req_valid) req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (last) messages_sent++;
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Hold the sender until every owed character has been seen, then let
   // the pipe settle. Config writes only happen after this.
   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic write_line_limit(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= {24'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      limit_shadow = value;
      limits_used++;
   endtask

   // Random byte, biased toward the classes the encoder treats differently
   function automatic logic [7:0] pick_byte();
      int         roll;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         b = 8'($urandom_range(8'h21, 8'h7E));          // printable
      end else if (roll < 55) begin
         b = QP_SPECIALS[$urandom_range(0, 15) * 8 +: 8];
      end else if (roll < 65) begin
         b = 8'($urandom_range(8'h80, 8'hFF));          // high half
      end else if (roll < 75) begin
         b = ($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB;
      end else if (roll < 83) begin
         b = CH_CR;
      end else if (roll < 91) begin
         b = CH_LF;
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // One message: random bytes, CR usually followed by LF, last one flagged
   task automatic send_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = pick_byte();
         send_byte(b, i == len - 1);
         if (b == CH_CR && i < len - 1 && $urandom_range(0, 3) != 0) begin
            i++;
            send_byte(CH_LF, i == len - 1);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: ready pattern is redrawn whenever rx_cycle[5:0] is zero,
   // including stretches where it never stalls
   // ---------------------------------------------------------------------
   logic [31:0] rx_cycle = '0;
   logic [1:0]  rx_mode  = '0;

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
         2'd0: begin
            rsp_ready <= 1'b1;
         end
         2'd1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         2'd2: begin
            // fixed stall while rx_cycle[2:0] is 5 or 6
            rsp_ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Monitor: each rsp_ transfer against the oldest owed character
   // ---------------------------------------------------------------------
   qpe_rsp_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected transfer: out_char 8'h%02h run_end %0b",
                   rsp_data.out_char, rsp_data.run_end);
            errors++;
         end else begin
            owed = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.out_char !== owed.out_char) begin
               $error("out_char: expected 8'h%02h, actual 8'h%02h",
                      owed.out_char, rsp_data.out_char);
               errors++;
            end
            if (rsp_data.run_end !== owed.run_end) begin
               $error("run_end: expected %0b, actual %0b",
                      owed.run_end, rsp_data.run_end);
               errors++;
            end
         end
      end
   end

   // Watchdog: any transfer on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_penable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset limit of 75: NUL, plain, specials, DEL, the high-half edges,
   // space/tab mid-message and at the end, CR, LF after CR, bare LF.
   task automatic test_byte_classes();
      send_byte(8'h00, 1'b0);
      send_byte("A", 1'b0);
      send_byte("~", 1'b0);
      send_byte("=", 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);      // follows CR: LF alone
      send_byte(CH_LF, 1'b0);      // bare: CR LF
      send_byte(CH_CR, 1'b1);      // final CR clears the CR history
      send_byte(CH_LF, 1'b0);      // so this one is bare again
      send_byte(CH_SPACE, 1'b1);   // trailing space escaped
      send_byte(CH_TAB, 1'b1);     // trailing tab escaped
      send_byte(CH_LF, 1'b1);
   endtask

   // Soft breaks at the low end of the range, then a limit so small that
   // an escape does not fit at all and lands on a line by itself.
   task automatic test_soft_breaks();
      wait_drained();
      write_line_limit(8'd8);
      for (int i = 0; i < 6; i++) send_byte(8'(8'h61 + i), 1'b0);
      send_byte("=", 1'b0);        // 6 + 3 > 8: break first
      send_byte("g", 1'b1);
      wait_drained();
      write_line_limit(8'd2);
      send_byte("?", 1'b0);        // empty line: no break despite width
      send_byte(8'hC3, 1'b0);
      send_byte("z", 1'b1);
   endtask

   // Random messages under several limits, both ends of the range included
   task automatic test_random_messages();
      logic [7:0] limits [5];
      int         start;
      int         len;
      limits[0] = 8'd255;
      limits[1] = 8'd8;
      limits[2] = 8'($urandom_range(9, 254));
      limits[3] = 8'd3;
      limits[4] = LINE_LIMIT_RESET;
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_line_limit(limits[p]);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_ITEMS) begin
            // mostly short messages, clipped to what is left of the phase
            len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 10);
            if (len > PHASE_ITEMS - (bytes_sent - start)) begin
               len = PHASE_ITEMS - (bytes_sent - start);
            end
            send_message(len);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_byte_classes();
      test_soft_breaks();
      test_random_messages();
      wait_drained();
      $display("Encoded %0d bytes in %0d messages under %0d line limits, %0d soft breaks.",
               bytes_sent, messages_sent, limits_used, soft_breaks);
      $display("Compared %0d output characters with their predicted values.",
               chars_checked);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
